### rtl/fgn_pkg.sv
// Shared constants and the elaboration-time sine table function for the fractal noise core.
package fgn_pkg;

   localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
   localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
   localparam logic [31:0] HASH_MUL_C = 32'd2048419325;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int ONE_Q15 = 32768;
   localparam int CFG_W = 4;
   localparam logic [CFG_W-1:0] OCTAVE_RESET = 4'd3;

   // shift-and-subtract quotient, only evaluated while building tables
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sin(pi/2 * r / 2^qbits) in Q15, Taylor series to the 15th power
   function automatic logic [16:0] quarter_sine(input int unsigned r, input int unsigned qbits);
      longint unsigned theta;
      longint unsigned term;
      longint signed   acc;
      longint signed   q;
      theta = (longint'(r) * HALF_PI_Q30) >> qbits;
      term  = theta;
      acc   = longint'(theta);
      for (int k = 1; k <= 7; k++) begin
         term = (((term * theta) >> 30) * theta) >> 30;
         term = udiv(term, 64'((2 * k) * (2 * k + 1)));
         if ((k & 1) == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      q = (acc + 16384) >>> 15;
      if (q > ONE_Q15) begin
         q = ONE_Q15;
      end
      return 17'(q);
   endfunction

endpackage

### rtl/fgn_cell.sv
// One octave cell: hash, gradient, dot products, smoothstep blend, accumulate, pass on.
module fgn_cell #(
   parameter int OCT             = 0,
   parameter int MAX_OCTAVES     = 8,
   parameter int ANGLE_TABLE_BITS = 10,
   parameter int COORD_FRAC_BITS = 16,
   parameter int ACC_W           = 28,
   parameter int OW              = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic [OW-1:0]           oct_eff,
   input  logic                    in_valid,
   input  logic signed [31:0]      in_x,
   input  logic signed [31:0]      in_y,
   input  logic signed [ACC_W-1:0] in_acc,
   output logic                    out_valid,
   output logic signed [31:0]      out_x,
   output logic signed [31:0]      out_y,
   output logic signed [ACC_W-1:0] out_acc
);

   localparam int LAT = 9;
   localparam int F   = COORD_FRAC_BITS;
   localparam int AB  = ANGLE_TABLE_BITS;
   localparam int QB  = AB - 2;
   localparam int Q   = 1 << QB;
   localparam int K   = MAX_OCTAVES - 1;

   // quarter sine table, entries 0..Q
   logic [16:0] sine_tab [0:Q];
   for (genvar g = 0; g <= Q; g++) begin : g_tab
      localparam logic [16:0] V = fgn_pkg::quarter_sine(g, QB);
      assign sine_tab[g] = V;
   end

   function automatic logic [31:0] rot16(input logic [31:0] v);
      return {v[15:0], v[31:16]};
   endfunction

   // sample carry line
   logic [LAT-1:0]          valid_ff;
   logic signed [31:0]      x_ff   [LAT];
   logic signed [31:0]      y_ff   [LAT];
   logic signed [ACC_W-1:0] acc_ff [LAT-1];
   logic signed [ACC_W-1:0] acc_out_ff;

   // stage 1
   logic [63:0] xs_in, ys_in;
   logic [31:0] cx_in, cy_in;
   logic [F+14:0] fxe_in, fye_in;
   logic [31:0] a0_in, a1_in;
   logic [31:0] a1_ff [2];
   logic [31:0] cy1_ff [2];
   logic [14:0] fx1_ff, fy1_ff;

   assign xs_in  = {{32{in_x[31]}}, in_x} << OCT;
   assign ys_in  = {{32{in_y[31]}}, in_y} << OCT;
   assign cx_in  = xs_in[F+31:F];
   assign cy_in  = ys_in[F+31:F];
   assign fxe_in = {xs_in[F-1:0], 15'd0};
   assign fye_in = {ys_in[F-1:0], 15'd0};
   assign a0_in  = cx_in * fgn_pkg::HASH_MUL_A;
   assign a1_in  = (cx_in + 32'd1) * fgn_pkg::HASH_MUL_A;

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff[0]  <= a0_in;
         a1_ff[1]  <= a1_in;
         cy1_ff[0] <= cy_in;
         cy1_ff[1] <= cy_in + 32'd1;
         fx1_ff    <= fxe_in[F+14:F];
         fy1_ff    <= fye_in[F+14:F];
      end
   end

   // stage 2: corner order 00, 10, 01, 11
   logic [31:0] b_in [4];
   logic [31:0] b2_ff [4];
   logic [31:0] a2_ff [4];
   logic [30:0] wwx_in, wwy_in;
   logic [15:0] w2x_ff, w2y_ff;
   logic [14:0] fx2_ff, fy2_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         b_in[c] = (cy1_ff[c / 2] ^ rot16(a1_ff[c % 2])) * fgn_pkg::HASH_MUL_B;
      end
   end
   assign wwx_in = fx1_ff * fx1_ff;
   assign wwy_in = fy1_ff * fy1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            b2_ff[c] <= b_in[c];
            a2_ff[c] <= a1_ff[c % 2];
         end
         w2x_ff <= 16'((wwx_in + 31'd16384) >> 15);
         w2y_ff <= 16'((wwy_in + 31'd16384) >> 15);
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
      end
   end

   // stage 3
   logic [31:0] h3_ff [4];
   logic [16:0] tx_in, ty_in;
   logic [33:0] wtx_in, wty_in;
   logic [17:0] sx3_ff, sy3_ff;
   logic [14:0] fx3_ff, fy3_ff;

   assign tx_in  = 17'd98304 - {1'b0, fx2_ff, 1'b0};
   assign ty_in  = 17'd98304 - {1'b0, fy2_ff, 1'b0};
   assign wtx_in = w2x_ff * tx_in;
   assign wty_in = w2y_ff * ty_in;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            h3_ff[c] <= (a2_ff[c] ^ rot16(b2_ff[c])) * fgn_pkg::HASH_MUL_C;
         end
         sx3_ff <= 18'((wtx_in + 34'd16384) >> 15);
         sy3_ff <= 18'((wty_in + 34'd16384) >> 15);
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
      end
   end

   // stage 4: gradient lookup
   logic signed [16:0] gx_in [4], gy_in [4];
   logic signed [16:0] gx4_ff [4], gy4_ff [4];
   logic [17:0] sx4_ff, sy4_ff;
   logic [14:0] fx4_ff, fy4_ff;

   always_comb begin
      logic [AB-1:0] p;
      logic [1:0]    quad;
      logic [QB-1:0] r;
      logic [QB:0]   ci;
      logic signed [16:0] sv, cv;
      for (int c = 0; c < 4; c++) begin
         p    = h3_ff[c][31:32-AB];
         quad = p[AB-1:AB-2];
         r    = p[QB-1:0];
         ci   = (QB+1)'(Q) - {1'b0, r};
         sv   = sine_tab[r];
         cv   = sine_tab[ci];
         case (quad)
            2'd0: begin gx_in[c] = cv;  gy_in[c] = sv;  end
            2'd1: begin gx_in[c] = -sv; gy_in[c] = cv;  end
            2'd2: begin gx_in[c] = -cv; gy_in[c] = -sv; end
            default: begin gx_in[c] = sv; gy_in[c] = -cv; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            gx4_ff[c] <= gx_in[c];
            gy4_ff[c] <= gy_in[c];
         end
         sx4_ff <= sx3_ff;
         sy4_ff <= sy3_ff;
         fx4_ff <= fx3_ff;
         fy4_ff <= fy3_ff;
      end
   end

   // stage 5: corner dot products
   logic signed [16:0] dx0, dx1, dy0, dy1;
   logic signed [16:0] dx_c [4], dy_c [4];
   logic signed [33:0] px_in [4], py_in [4];
   logic signed [34:0] ds_in [4];
   logic signed [34:0] dr_in [4];
   logic signed [19:0] n5_ff [4];
   logic [17:0] sx5_ff, sy5_ff;

   assign dx0 = {2'b00, fx4_ff};
   assign dy0 = {2'b00, fy4_ff};
   assign dx1 = dx0 - 17'sd32768;
   assign dy1 = dy0 - 17'sd32768;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         dx_c[c]  = (c % 2 == 1) ? dx1 : dx0;
         dy_c[c]  = (c >= 2) ? dy1 : dy0;
         px_in[c] = dx_c[c] * gx4_ff[c];
         py_in[c] = dy_c[c] * gy4_ff[c];
         ds_in[c] = 35'(px_in[c]) + 35'(py_in[c]);
         dr_in[c] = (ds_in[c] + 35'sd16384) >>> 15;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            n5_ff[c] <= dr_in[c][19:0];
         end
         sx5_ff <= sx4_ff;
         sy5_ff <= sy4_ff;
      end
   end

   // stage 6: x blend products
   logic signed [20:0] d0_in, d1_in;
   logic signed [18:0] sxs_in;
   logic signed [39:0] p0_in, p1_in;
   logic signed [39:0] p0_ff, p1_ff;
   logic signed [19:0] n0_6_ff, n2_6_ff;
   logic [17:0] sy6_ff;

   assign d0_in  = 21'(n5_ff[1]) - 21'(n5_ff[0]);
   assign d1_in  = 21'(n5_ff[3]) - 21'(n5_ff[2]);
   assign sxs_in = {1'b0, sx5_ff};
   assign p0_in  = d0_in * sxs_in;
   assign p1_in  = d1_in * sxs_in;

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         n0_6_ff <= n5_ff[0];
         n2_6_ff <= n5_ff[2];
         sy6_ff  <= sy5_ff;
      end
   end

   // stage 7: finish x blends
   logic signed [39:0] r0_in, r1_in;
   logic signed [20:0] e0_ff, e1_ff;
   logic [17:0] sy7_ff;

   assign r0_in = (p0_ff + 40'sd16384) >>> 15;
   assign r1_in = (p1_ff + 40'sd16384) >>> 15;

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff  <= 21'(n0_6_ff) + r0_in[20:0];
         e1_ff  <= 21'(n2_6_ff) + r1_in[20:0];
         sy7_ff <= sy6_ff;
      end
   end

   // stage 8: y blend product
   logic signed [21:0] de_in;
   logic signed [18:0] sys_in;
   logic signed [40:0] q_in;
   logic signed [40:0] q_ff;
   logic signed [20:0] e0_8_ff;

   assign de_in  = 22'(e1_ff) - 22'(e0_ff);
   assign sys_in = {1'b0, sy7_ff};
   assign q_in   = de_in * sys_in;

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff    <= q_in;
         e0_8_ff <= e0_ff;
      end
   end

   // stage 9: octave noise, weight and accumulate
   logic signed [40:0]      qr_in;
   logic signed [20:0]      n_in;
   logic signed [ACC_W-1:0] nw_in;
   logic                    active_in;

   assign qr_in     = (q_ff + 41'sd16384) >>> 15;
   assign n_in      = e0_8_ff + qr_in[20:0];
   assign nw_in     = ACC_W'(n_in) <<< (K - OCT);
   assign active_in = (OW'(OCT) < oct_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= in_x;
         y_ff[0]   <= in_y;
         acc_ff[0] <= in_acc;
         for (int j = 1; j < LAT; j++) begin
            x_ff[j] <= x_ff[j-1];
            y_ff[j] <= y_ff[j-1];
         end
         for (int j = 1; j < LAT - 1; j++) begin
            acc_ff[j] <= acc_ff[j-1];
         end
         acc_out_ff <= active_in ? acc_ff[LAT-2] + nw_in : acc_ff[LAT-2];
      end
   end

   assign out_valid = valid_ff[LAT-1];
   assign out_x     = x_ff[LAT-1];
   assign out_y     = y_ff[LAT-1];
   assign out_acc   = acc_out_ff;

endmodule

### rtl/fractal_gradient_noise_2d_core.sv
// Top level of the fractal gradient noise core: octave cell chain and normalization.
// Fractal 2D gradient noise: each req word carries a Q16.16 point and yields one
// rsp word holding Q1.15 noise summed over octave_count octaves (csr, 0 acts as 1,
// values above MAX_OCTAVES act as MAX_OCTAVES). Words enter one per cycle; the
// chain holds one cell per octave, 9 stages each, and 2 normalization stages
// follow; throughput is one word per clock while the rsp word is taken.
// The whole pipe stalls while the rsp word waits. Write csr only when idle.
module fractal_gradient_noise_2d_core #(
   parameter int MAX_OCTAVES      = 8,
   parameter int ANGLE_TABLE_BITS = 10,
   parameter int COORD_FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] x_coord, [63:32] y_coord
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [15:0] noise_value
);

   localparam int K     = MAX_OCTAVES - 1;
   localparam int ACC_W = 20 + MAX_OCTAVES;
   localparam int OW    = $clog2(MAX_OCTAVES + 1);
   localparam int IW    = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int RW    = 30;
   localparam int PW    = ACC_W + RW + 1;

   logic [3:0]    octave_ff;
   logic [OW-1:0] oct_eff;
   logic          en;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff <= fgn_pkg::OCTAVE_RESET;
      end else if (csr_we) begin
         octave_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (octave_ff == 4'd0) begin
         oct_eff = OW'(1);
      end else if (5'(octave_ff) > 5'(MAX_OCTAVES)) begin
         oct_eff = OW'(MAX_OCTAVES);
      end else begin
         oct_eff = OW'(octave_ff);
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // octave chain
   logic                    c_valid [MAX_OCTAVES+1];
   logic signed [31:0]      c_x     [MAX_OCTAVES+1];
   logic signed [31:0]      c_y     [MAX_OCTAVES+1];
   logic signed [ACC_W-1:0] c_acc   [MAX_OCTAVES+1];

   assign c_valid[0] = req_tvalid;
   assign c_x[0]     = req_tdata[31:0];
   assign c_y[0]     = req_tdata[63:32];
   assign c_acc[0]   = '0;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
      fgn_cell #(
         .OCT              (i),
         .MAX_OCTAVES      (MAX_OCTAVES),
         .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS),
         .COORD_FRAC_BITS  (COORD_FRAC_BITS),
         .ACC_W            (ACC_W),
         .OW               (OW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .oct_eff   (oct_eff),
         .in_valid  (c_valid[i]),
         .in_x      (c_x[i]),
         .in_y      (c_y[i]),
         .in_acc    (c_acc[i]),
         .out_valid (c_valid[i+1]),
         .out_x     (c_x[i+1]),
         .out_y     (c_y[i+1]),
         .out_acc   (c_acc[i+1])
      );
   end

   // reciprocal of the total amplitude per octave count
   logic [RW-1:0] recip_tab [MAX_OCTAVES];
   for (genvar g = 1; g <= MAX_OCTAVES; g++) begin : g_recip
      localparam longint TOT = (longint'(1) << (K + 1)) - (longint'(1) << (K + 1 - g));
      localparam longint RCP = ((longint'(1) << (28 + K)) + TOT / 2) / TOT;
      assign recip_tab[g-1] = RW'(RCP);
   end

   logic [IW-1:0]       ridx;
   logic signed [RW:0]  recip_s;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_ff;
   logic                 prod_valid_ff;
   logic signed [PW-1:0] res_in;
   logic [15:0]          sat_in;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff;

   assign ridx    = IW'(oct_eff - OW'(1));
   assign recip_s = {1'b0, recip_tab[ridx]};
   assign prod_in = c_acc[MAX_OCTAVES] * recip_s;
   assign res_in  = (prod_ff + (PW'(1) <<< (27 + K))) >>> (28 + K);

   always_comb begin
      if (res_in > PW'(32767)) begin
         sat_in = 16'h7FFF;
      end else if (res_in < -PW'(32768)) begin
         sat_in = 16'h8000;
      end else begin
         sat_in = res_in[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= c_valid[MAX_OCTAVES];
         rsp_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= prod_in;
         rsp_data_ff <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/fgn_checker.sv
// Port-level checks for the fractal noise core, bound to the top level.
module fgn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word dropped or changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_ready_on_take: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req stalled while rsp side takes words");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

endmodule

bind fractal_gradient_noise_2d_core fgn_checker u_fgn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/fractal_gradient_noise_2d_core_tb.sv
// Self-checking testbench for the fractal gradient noise core with a bit-true noise predictor.
module fractal_gradient_noise_2d_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_OCT   = 8;
   localparam int QBITS     = 8;
   localparam int FRAC      = 16;
   localparam int LATENCY   = 9 * NUM_OCT + 2;
   localparam int WDOG_MAX  = 5000;
   localparam int N_RANDOM  = 1750;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [3:0]  oct;
      bit          has_val;
      logic [15:0] val;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic [3:0]  octave_setting = fgn_pkg::OCTAVE_RESET;
   logic [15:0] noise_expected[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   int          rsp_gap = 0;
   bit          calm_phase = 1'b0;
   bit          hold_rsp = 1'b0;
   bit          timed_out = 1'b0;
   int          sine_lut[0:(1<<QBITS)];

   fractal_gradient_noise_2d_core u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic int sine_q15(int unsigned r);
      longint unsigned theta, term;
      longint signed   acc, q;
      theta = (longint'(r) * 64'd1686629713) >> QBITS;
      term  = theta;
      acc   = longint'(theta);
      for (int k = 1; k <= 7; k++) begin
         term = (((term * theta) >> 30) * theta) >> 30;
         term = term / longint'((2 * k) * (2 * k + 1));
         acc  = (k & 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      q = (acc + 16384) >>> 15;
      return (q > 32768) ? 32768 : int'(q);
   endfunction

   function automatic logic [31:0] rot_half(logic [31:0] v);
      return {v[15:0], v[31:16]};
   endfunction

   function automatic longint lattice_dot(logic [31:0] cx, logic [31:0] cy,
                                          longint dx, longint dy);
      logic [31:0] a, b, h;
      int unsigned p, quad, r;
      longint s, c, gx, gy;
      a = cx * fgn_pkg::HASH_MUL_A;
      b = (cy ^ rot_half(a)) * fgn_pkg::HASH_MUL_B;
      a = a ^ rot_half(b);
      h = a * fgn_pkg::HASH_MUL_C;
      p = 32'(h[31:22]);
      quad = p >> QBITS;
      r = p & ((1 << QBITS) - 1);
      s = sine_lut[r];
      c = sine_lut[(1 << QBITS) - r];
      case (quad)
         0: begin gx = c;  gy = s;  end
         1: begin gx = -s; gy = c;  end
         2: begin gx = -c; gy = -s; end
         default: begin gx = s; gy = -c; end
      endcase
      return round_shift(dx * gx + dy * gy, 15);
   endfunction

   function automatic longint fade(longint w);
      longint w2;
      w2 = (w * w + 16384) >>> 15;
      return (w2 * (98304 - 2 * w) + 16384) >>> 15;
   endfunction

   function automatic longint mix(longint a0, longint a1, longint s);
      return a0 + round_shift((a1 - a0) * s, 15);
   endfunction

   function automatic longint octave_value(longint x, longint y, int i);
      logic [63:0] ux, uy;
      logic [31:0] cx, cy;
      longint fx, fy, sx, sy;
      ux = 64'(x <<< i);
      uy = 64'(y <<< i);
      cx = ux[47:16];
      cy = uy[47:16];
      fx = longint'(ux[15:1]);
      fy = longint'(uy[15:1]);
      sx = fade(fx);
      sy = fade(fy);
      return mix(mix(lattice_dot(cx, cy, fx, fy), lattice_dot(cx + 1, cy, fx - 32768, fy), sx),
                 mix(lattice_dot(cx, cy + 1, fx, fy - 32768),
                     lattice_dot(cx + 1, cy + 1, fx - 32768, fy - 32768), sx), sy);
   endfunction

   function automatic logic [15:0] fractal_noise(logic [31:0] xc, logic [31:0] yc,
                                                 logic [3:0] oct_reg);
      int oct;
      longint acc, total, recip, res;
      oct = (oct_reg < 1) ? 1 : (oct_reg > NUM_OCT) ? NUM_OCT : int'(oct_reg);
      acc = 0;
      total = 0;
      for (int i = 0; i < oct; i++) begin
         acc   += octave_value(longint'(signed'(xc)), longint'(signed'(yc)), i)
                  * (longint'(1) << (NUM_OCT - 1 - i));
         total += longint'(1) << (NUM_OCT - 1 - i);
      end
      recip = ((longint'(1) << (27 + NUM_OCT)) + total / 2) / total;
      res = round_shift(acc * recip, 27 + NUM_OCT);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return res[15:0];
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatch_count++;
      $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got), $signed(want),
               $realtime);
   endtask

   task automatic send_word(logic [31:0] xc, logic [31:0] yc);
      req_tvalid <= 1'b1;
      req_tdata  <= {yc, xc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      noise_expected.push_back(fractal_noise(xc, yc, octave_setting));
   endtask

   task automatic sender_gap();
      int n;
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_and_write(logic [3:0] v);
      req_tvalid <= 1'b0;
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      octave_setting = v;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
         default: return $urandom_range(0, 1) ? 32'h7FFF_0000 + $urandom_range(0, 65535)
                                              : 32'h8000_0000 + $urandom_range(0, 65535);
      endcase
   endfunction

   // check results
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (noise_expected.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 16'h0);
         end else begin
            want = noise_expected.pop_front();
            if (rsp_tdata !== want) report_mismatch("noise_value", rsp_tdata, want);
         end
      end
   end

   // receiver stalls in random bursts, except in the calm phase
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else if (calm_phase) begin
         rsp_tready <= 1'b1;
         rsp_gap    <= 0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= rsp_gap - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on accepted words
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog expired");
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      for (int r = 0; r <= (1 << QBITS); r++) sine_lut[r] = sine_q15(r);
      // lattice points give zero noise
      rows.push_back('{32'h0, 32'h0, 4'd3, 1'b1, 16'h0});
      rows.push_back('{32'h0001_0000, 32'h0005_0000, 4'd3, 1'b1, 16'h0});
      rows.push_back('{32'h8000_0000, 32'h8000_0000, 4'd1, 1'b1, 16'h0});
      rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd1, 1'b0, 16'h0});
      rows.push_back('{32'h8000_0001, 32'h7FFF_FFFF, 4'd0, 1'b0, 16'h0});
      rows.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 4'd8, 1'b0, 16'h0});
      rows.push_back('{32'h7FFF_8000, 32'hFFFF_8000, 4'd8, 1'b0, 16'h0});
      rows.push_back('{32'h0000_8000, 32'h0000_8000, 4'd15, 1'b0, 16'h0});
      rows.push_back('{32'hFFFF_0000, 32'h0000_FFFF, 4'd9, 1'b0, 16'h0});
      rows.push_back('{32'h1234_5678, 32'h9ABC_DEF0, 4'd2, 1'b0, 16'h0});
      rows.push_back('{32'h0000_4000, 32'hFFFF_C000, 4'd5, 1'b0, 16'h0});
      rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 4'd8, 1'b0, 16'h0});
      rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 4'd4, 1'b0, 16'h0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         row = rows[i];
         if (row.oct != octave_setting) drain_and_write(row.oct);
         if (row.has_val && fractal_noise(row.x, row.y, row.oct) != row.val)
            $display("note: table value disagrees with predictor");
         send_word(row.x, row.y);
         if (row.has_val) noise_expected[$] = row.val;
         sender_gap();
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 250 == 0) drain_and_write(n == 0 ? 4'd8 : 4'($urandom_range(0, 15)));
         if (n == 500) begin
            hold_rsp = 1'b1;
            fork
               begin repeat (300) @(posedge clock); hold_rsp = 1'b0; end
            join_none
         end
         if (n == 900) begin
            req_tvalid <= 1'b0;
            while (noise_expected.size() != 0) @(posedge clock);
         end
         if (n == N_RANDOM - 200) calm_phase = 1'b1;
         send_word(rand_coord(), rand_coord());
         sender_gap();
      end
      req_tvalid <= 1'b0;

      fork
         begin
            while (noise_expected.size() != 0) @(posedge clock);
            repeat (LATENCY + 10) @(posedge clock);
         end
         begin
            repeat (200000) @(posedge clock);
            timed_out = 1'b1;
         end
      join_any
      if (timed_out) begin
         $display("CHECK FAILED");
      end else if (mismatch_count == 0 && noise_expected.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
